>>> rtl/pncs_pkg.sv
package pncs_pkg;

  localparam int INDEX_W  = 8;
  localparam int CHAN_W   = 8;
  localparam int DIST_W   = 10;
  localparam int STATUS_W = 2;
  localparam int SIZE_W   = 9;

  localparam logic [STATUS_W-1:0] STATUS_OK          = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_NOT_INDEXED = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_BAD_RANGE   = 2'd2;

  localparam logic CFG_PALETTE_SIZE = 1'b0;
  localparam logic CFG_INDEXED_MODE = 1'b1;

  localparam int S_TDATA_W = 48;
  localparam int M_TDATA_W = 24;

  // one transaction as it moves down the row of cells
  typedef struct packed {
    logic                is_query;
    logic [INDEX_W-1:0]  entry_index;
    logic [CHAN_W-1:0]   red;
    logic [CHAN_W-1:0]   green;
    logic [CHAN_W-1:0]   blue;
    logic [INDEX_W-1:0]  range_low;
    logic [INDEX_W-1:0]  range_high;
    logic                have;
    logic [INDEX_W-1:0]  best_index;
    logic [DIST_W-1:0]   best_distance;
    logic [STATUS_W-1:0] status;
  } pncs_token_t;

endpackage

>>> rtl/pncs_cell.sv
module pncs_cell #(
  parameter int CELL_INDEX = 0
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                advance,
  input  logic                in_valid,
  input  pncs_pkg::pncs_token_t in_tok,
  output logic                out_valid,
  output pncs_pkg::pncs_token_t out_tok
);

  localparam logic [pncs_pkg::INDEX_W-1:0] IDX = CELL_INDEX[pncs_pkg::INDEX_W-1:0];

  logic [pncs_pkg::CHAN_W-1:0] colour_r;
  logic [pncs_pkg::CHAN_W-1:0] colour_g;
  logic [pncs_pkg::CHAN_W-1:0] colour_b;
  logic [pncs_pkg::CHAN_W-1:0] diff_r;
  logic [pncs_pkg::CHAN_W-1:0] diff_g;
  logic [pncs_pkg::CHAN_W-1:0] diff_b;
  logic [pncs_pkg::DIST_W-1:0] dist_sum;
  logic                        in_range;
  logic                        take;
  logic                        write_hit;
  pncs_pkg::pncs_token_t       tok_next;

  always_comb begin
    diff_r = (in_tok.red > colour_r) ? in_tok.red - colour_r : colour_r - in_tok.red;
    diff_g = (in_tok.green > colour_g) ? in_tok.green - colour_g : colour_g - in_tok.green;
    diff_b = (in_tok.blue > colour_b) ? in_tok.blue - colour_b : colour_b - in_tok.blue;
    dist_sum = pncs_pkg::DIST_W'(diff_r) + pncs_pkg::DIST_W'(diff_g)
             + pncs_pkg::DIST_W'(diff_b);
    in_range  = (IDX >= in_tok.range_low) && (IDX <= in_tok.range_high);
    take      = in_valid && in_tok.is_query && (in_tok.status == pncs_pkg::STATUS_OK)
              && in_range && (!in_tok.have || (dist_sum < in_tok.best_distance));
    write_hit = in_valid && !in_tok.is_query && (in_tok.entry_index == IDX);
    tok_next  = in_tok;
    if (take) begin
      tok_next.have          = 1'b1;
      tok_next.best_index    = IDX;
      tok_next.best_distance = dist_sum;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_tok <= tok_next;
      if (write_hit) begin
        colour_r <= in_tok.red;
        colour_g <= in_tok.green;
        colour_b <= in_tok.blue;
      end
    end
  end

endmodule

>>> rtl/palette_nearest_color_search.sv
// channel   direction  handshake                    payload
// s_axis    in         s_axis_tvalid/s_axis_tready  tuser func, tdata entry, colour, range
// m_axis    out        m_axis_tvalid/m_axis_tready  tdata best_index, best_distance, status
// cfg       in         cfg_valid/cfg_ready          cfg_index, cfg_data
//
// While m_axis is not stalled, one transaction enters per cycle and each moves one cell
// per cycle down a row of PALETTE_DEPTH cells, each cell holding one palette entry.
// A query passes every cell register and then the output register before m_axis_tvalid.
// Writes travel the same row and land in their cell, so ordering is kept.
// A stall on m_axis freezes the whole row; s_axis_tready follows it.
// Reset clears control state and loads palette_size PALETTE_DEPTH, indexed_mode 1;
// palette entries are undefined until written.
module palette_nearest_color_search #(
  parameter int PALETTE_DEPTH = 256
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // [7:0] entry_index, [15:8] red, [23:16] green, [31:24] blue,
  // [39:32] range_low, [47:40] range_high
  input  logic [pncs_pkg::S_TDATA_W-1:0]      s_axis_tdata,
  // [0] func
  input  logic                                s_axis_tuser,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // [7:0] best_index, [17:8] best_distance, [19:18] status, [23:20] zero
  output logic [pncs_pkg::M_TDATA_W-1:0]      m_axis_tdata,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic                                cfg_index,
  input  logic [pncs_pkg::SIZE_W-1:0]         cfg_data
);

  localparam logic [pncs_pkg::SIZE_W-1:0] DEPTH_SZ = pncs_pkg::SIZE_W'(PALETTE_DEPTH);

  logic [pncs_pkg::SIZE_W-1:0] palette_size;
  logic                        indexed_mode;
  logic [pncs_pkg::SIZE_W-1:0] size_in_use;
  logic                        advance;

  logic                  chain_valid [0:PALETTE_DEPTH];
  pncs_pkg::pncs_token_t chain_tok   [0:PALETTE_DEPTH];
  pncs_pkg::pncs_token_t head_tok;
  pncs_pkg::pncs_token_t last_tok;

  assign cfg_ready     = 1'b1;
  assign advance       = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      palette_size <= DEPTH_SZ;
      indexed_mode <= 1'b1;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        pncs_pkg::CFG_PALETTE_SIZE: palette_size <= cfg_data;
        pncs_pkg::CFG_INDEXED_MODE: indexed_mode <= cfg_data[0];
        default: ;
      endcase
    end
  end

  assign size_in_use = (palette_size > DEPTH_SZ) ? DEPTH_SZ : palette_size;

  always_comb begin
    head_tok.is_query       = s_axis_tuser;
    head_tok.entry_index    = s_axis_tdata[7:0];
    head_tok.red            = s_axis_tdata[15:8];
    head_tok.green          = s_axis_tdata[23:16];
    head_tok.blue           = s_axis_tdata[31:24];
    head_tok.range_low      = s_axis_tdata[39:32];
    head_tok.range_high     = s_axis_tdata[47:40];
    head_tok.have           = 1'b0;
    head_tok.best_index     = '0;
    head_tok.best_distance  = '0;
    if (!indexed_mode) begin
      head_tok.status = pncs_pkg::STATUS_NOT_INDEXED;
    end else if ((s_axis_tdata[39:32] > s_axis_tdata[47:40])
                 || ({1'b0, s_axis_tdata[47:40]} >= size_in_use)) begin
      head_tok.status = pncs_pkg::STATUS_BAD_RANGE;
    end else begin
      head_tok.status = pncs_pkg::STATUS_OK;
    end
  end

  assign chain_valid[0] = s_axis_tvalid;
  assign chain_tok[0]   = head_tok;

  for (genvar g = 0; g < PALETTE_DEPTH; g++) begin : g_cell
    pncs_cell #(
      .CELL_INDEX(g)
    ) u_cell (
      .clk      (clk),
      .rst      (rst),
      .advance  (advance),
      .in_valid (chain_valid[g]),
      .in_tok   (chain_tok[g]),
      .out_valid(chain_valid[g+1]),
      .out_tok  (chain_tok[g+1])
    );
  end

  assign last_tok = chain_tok[PALETTE_DEPTH];

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (advance) begin
      m_axis_tvalid <= chain_valid[PALETTE_DEPTH] && last_tok.is_query;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      m_axis_tdata <= {4'b0000, last_tok.status, last_tok.best_distance,
                       last_tok.best_index};
    end
  end

endmodule

>>> rtl/pncs_checker.sv
module pncs_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           s_axis_tready,
  input logic                           m_axis_tvalid,
  input logic                           m_axis_tready,
  input logic [pncs_pkg::M_TDATA_W-1:0] m_axis_tdata
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  a_in_ready: assert property (@(posedge clk) disable iff (rst)
    s_axis_tready == (!m_axis_tvalid || m_axis_tready))
    else $error("input ready does not follow output stall");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (m_axis_tdata[19:18] == pncs_pkg::STATUS_OK)
                   || (m_axis_tdata[19:18] == pncs_pkg::STATUS_NOT_INDEXED)
                   || (m_axis_tdata[19:18] == pncs_pkg::STATUS_BAD_RANGE))
    else $error("bad status code");

  a_error_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && (m_axis_tdata[19:18] != pncs_pkg::STATUS_OK)
      |-> (m_axis_tdata[17:0] == 18'd0))
    else $error("error result carries index or distance");

  a_dist_max: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (m_axis_tdata[17:8] <= 10'd765) && (m_axis_tdata[23:20] == 4'd0))
    else $error("distance out of range");

endmodule

bind palette_nearest_color_search pncs_checker u_pncs_checker (
  .clk          (clk),
  .rst          (rst),
  .s_axis_tready(s_axis_tready),
  .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready),
  .m_axis_tdata (m_axis_tdata)
);

>>> sim/palette_nearest_color_search_tb.sv
`timescale 1ns / 1ps

module palette_nearest_color_search_tb;

  localparam int PALETTE_DEPTH = 256;
  localparam int CYCLE_LIMIT   = 400000;
  localparam int LONG_HOLD     = 1200;

  typedef enum logic {
    OP_WRITE_ENTRY = 1'b0,
    OP_QUERY       = 1'b1
  } pixel_op_t;

  typedef enum logic [1:0] {
    RX_OPEN,
    RX_CHOPPY,
    RX_SPARSE
  } rx_mode_t;

  typedef struct packed {
    pixel_op_t                    op;
    logic [pncs_pkg::INDEX_W-1:0] entry_index;
    logic [pncs_pkg::CHAN_W-1:0]  red;
    logic [pncs_pkg::CHAN_W-1:0]  green;
    logic [pncs_pkg::CHAN_W-1:0]  blue;
    logic [pncs_pkg::INDEX_W-1:0] range_low;
    logic [pncs_pkg::INDEX_W-1:0] range_high;
  } pixel_txn_t;

  typedef struct packed {
    logic [pncs_pkg::INDEX_W-1:0]  best_index;
    logic [pncs_pkg::DIST_W-1:0]   best_distance;
    logic [pncs_pkg::STATUS_W-1:0] status;
  } match_t;

  logic                           clk = 1'b0;
  logic                           rst = 1'b1;
  logic                           s_axis_tvalid = 1'b0;
  logic                           s_axis_tready;
  logic [pncs_pkg::S_TDATA_W-1:0] s_axis_tdata = '0;
  logic                           s_axis_tuser = 1'b0;
  logic                           m_axis_tvalid;
  logic                           m_axis_tready = 1'b0;
  logic [pncs_pkg::M_TDATA_W-1:0] m_axis_tdata;
  logic                           cfg_valid = 1'b0;
  logic                           cfg_ready;
  logic                           cfg_index = 1'b0;
  logic [pncs_pkg::SIZE_W-1:0]    cfg_data = '0;

  palette_nearest_color_search #(
    .PALETTE_DEPTH(PALETTE_DEPTH)
  ) uut (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // predictor state: palette copy and register copies
  logic [3*pncs_pkg::CHAN_W-1:0] palette_shadow [PALETTE_DEPTH];
  int unsigned                   size_setting = PALETTE_DEPTH;
  logic                          indexed_setting = 1'b1;

  // colours as planned by the stimulus, used to aim queries at real entries
  logic [3*pncs_pkg::CHAN_W-1:0] planned_colours [PALETTE_DEPTH];

  pixel_txn_t  pending_q [$];
  match_t      expected_matches [$];
  pixel_txn_t  cur_txn = '0;
  int unsigned issued_count = 0;
  int unsigned accepted_count = 0;
  int unsigned err_count = 0;
  int unsigned cycle_count = 0;

  int unsigned burst_left = 1;
  int unsigned gap_left = 0;
  logic        offering;

  rx_mode_t    rx_mode = RX_OPEN;
  int unsigned mode_left = 0;
  int unsigned hold_left = 0;
  logic        long_hold_req = 1'b0;
  logic        long_hold_done = 1'b0;
  logic        ready_next;

  function automatic int unsigned channel_gap(input logic [pncs_pkg::CHAN_W-1:0] a,
                                              input logic [pncs_pkg::CHAN_W-1:0] b);
    return (a > b) ? int'(a - b) : int'(b - a);
  endfunction

  function automatic match_t nearest_entry(input pixel_txn_t q);
    match_t                        m;
    int unsigned                   size_in_use;
    int unsigned                   dist_sum;
    int unsigned                   k;
    logic [3*pncs_pkg::CHAN_W-1:0] rgb;
    m = '0;
    m.status = pncs_pkg::STATUS_OK;
    size_in_use = (size_setting > PALETTE_DEPTH) ? PALETTE_DEPTH : size_setting;
    if (indexed_setting != 1'b1) begin
      m.status = pncs_pkg::STATUS_NOT_INDEXED;
    end else if (q.range_low > q.range_high || q.range_high >= size_in_use) begin
      m.status = pncs_pkg::STATUS_BAD_RANGE;
    end else begin
      for (k = q.range_low; k <= q.range_high; k++) begin
        rgb = palette_shadow[k];
        dist_sum = channel_gap(q.red, rgb[23:16]) + channel_gap(q.green, rgb[15:8])
                 + channel_gap(q.blue, rgb[7:0]);
        if (k == q.range_low || dist_sum < m.best_distance) begin
          m.best_distance = dist_sum[pncs_pkg::DIST_W-1:0];
          m.best_index    = k[pncs_pkg::INDEX_W-1:0];
        end
      end
    end
    return m;
  endfunction

  task automatic flag_error(input string what, input int unsigned got,
                            input int unsigned want);
    if (err_count < 40)
      $display("error at cycle %0d: %s got %0d want %0d", cycle_count, what, got, want);
    err_count++;
  endtask

  // driver: bursts of transactions separated by random gaps
  always @(posedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      offering = s_axis_tvalid;
      if (s_axis_tvalid && s_axis_tready) begin
        if (cur_txn.op == OP_WRITE_ENTRY)
          palette_shadow[cur_txn.entry_index] = {cur_txn.red, cur_txn.green, cur_txn.blue};
        else
          expected_matches.push_back(nearest_entry(cur_txn));
        accepted_count++;
        offering = 1'b0;
        if (burst_left > 0) burst_left--;
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 24);
          gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
        end
      end
      if (!offering) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (pending_q.size() != 0) begin
          cur_txn = pending_q.pop_front();
          offering = 1'b1;
        end
      end
      s_axis_tvalid <= offering;
      s_axis_tdata  <= {cur_txn.range_high, cur_txn.range_low, cur_txn.blue,
                        cur_txn.green, cur_txn.red, cur_txn.entry_index};
      s_axis_tuser  <= cur_txn.op;
    end
  end

  // receiver: stall pattern of its own, plus one long hold-off
  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (long_hold_req && !long_hold_done && m_axis_tvalid) begin
        hold_left = LONG_HOLD;
        long_hold_done = 1'b1;
      end
      if (mode_left == 0) begin
        rx_mode = rx_mode_t'($urandom_range(0, 2));
        mode_left = $urandom_range(20, 200);
      end else begin
        mode_left--;
      end
      if (hold_left > 0) begin
        hold_left--;
        ready_next = 1'b0;
      end else begin
        case (rx_mode)
          RX_OPEN:   ready_next = 1'b1;
          RX_CHOPPY: ready_next = ($urandom_range(0, 1) == 1);
          default:   ready_next = ($urandom_range(0, 3) == 0);
        endcase
      end
      m_axis_tready <= ready_next;
    end
  end

  // monitor
  always @(posedge clk) begin
    match_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (expected_matches.size() == 0) begin
        flag_error("unexpected result, tdata", m_axis_tdata, 0);
      end else begin
        want = expected_matches.pop_front();
        if (m_axis_tdata[7:0] != want.best_index)
          flag_error("best_index", m_axis_tdata[7:0], want.best_index);
        if (m_axis_tdata[17:8] != want.best_distance)
          flag_error("best_distance", m_axis_tdata[17:8], want.best_distance);
        if (m_axis_tdata[19:18] != want.status)
          flag_error("status", m_axis_tdata[19:18], want.status);
        if (m_axis_tdata[23:20] != '0)
          flag_error("padding", m_axis_tdata[23:20], 0);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("palette_nearest_color_search: mismatch");
      $finish;
    end
  end

  function automatic logic [pncs_pkg::CHAN_W-1:0] pick_channel();
    case ($urandom_range(0, 4))
      0:       return '0;
      1:       return '1;
      2:       return 8'd128;
      default: return pncs_pkg::CHAN_W'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic queue_item(input pixel_op_t op, input int unsigned idx,
                            input int unsigned r, input int unsigned g,
                            input int unsigned b, input int unsigned lo,
                            input int unsigned hi);
    pixel_txn_t t;
    t.op          = op;
    t.entry_index = idx[pncs_pkg::INDEX_W-1:0];
    t.red         = r[pncs_pkg::CHAN_W-1:0];
    t.green       = g[pncs_pkg::CHAN_W-1:0];
    t.blue        = b[pncs_pkg::CHAN_W-1:0];
    t.range_low   = lo[pncs_pkg::INDEX_W-1:0];
    t.range_high  = hi[pncs_pkg::INDEX_W-1:0];
    if (op == OP_WRITE_ENTRY) planned_colours[t.entry_index] = {t.red, t.green, t.blue};
    pending_q.push_back(t);
    issued_count++;
  endtask

  task automatic drain_block();
    do @(posedge clk);
    while (accepted_count != issued_count || expected_matches.size() != 0);
    // writes carry no result and may still be moving down the row
    repeat (PALETTE_DEPTH + 8) @(posedge clk);
  endtask

  task automatic program_register(input logic idx, input int unsigned val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val[pncs_pkg::SIZE_W-1:0];
    do @(posedge clk);
    while (!cfg_ready);
    if (idx == pncs_pkg::CFG_PALETTE_SIZE) size_setting = 32'(val[pncs_pkg::SIZE_W-1:0]);
    else indexed_setting = val[0];
    cfg_valid <= 1'b0;
  endtask

  task automatic queue_random_mix(input int unsigned count);
    int unsigned                   n;
    int unsigned                   size_in_use;
    int unsigned                   lo;
    int unsigned                   hi;
    int unsigned                   pick;
    logic [3*pncs_pkg::CHAN_W-1:0] rgb;
    size_in_use = (size_setting > PALETTE_DEPTH) ? PALETTE_DEPTH : size_setting;
    for (n = 0; n < count; n++) begin
      if ($urandom_range(0, 99) < 30) begin
        queue_item(OP_WRITE_ENTRY, $urandom_range(0, 255), pick_channel(), pick_channel(),
                   pick_channel(), $urandom, $urandom);
      end else begin
        pick = $urandom_range(0, 99);
        if (pick < 70) begin
          hi = $urandom_range(0, size_in_use - 1);
          if ($urandom_range(0, 1) && hi > 6) lo = hi - $urandom_range(0, 6);
          else lo = $urandom_range(0, hi);
        end else if (pick < 85) begin
          lo = $urandom_range(1, 255);
          hi = $urandom_range(0, lo - 1);
        end else if (size_in_use < PALETTE_DEPTH) begin
          hi = $urandom_range(size_in_use, 255);
          lo = $urandom_range(0, 255);
        end else begin
          hi = $urandom_range(0, 255);
          lo = $urandom_range(0, 255);
        end
        if ($urandom_range(0, 2) == 0) begin
          rgb = planned_colours[$urandom_range(0, 255)];
          if ($urandom_range(0, 1)) rgb[7:0] = rgb[7:0] ^ 8'd1;
        end else begin
          rgb = {pick_channel(), pick_channel(), pick_channel()};
        end
        queue_item(OP_QUERY, $urandom, rgb[23:16], rgb[15:8], rgb[7:0], lo, hi);
      end
    end
  endtask

  initial begin
    match_t left_over;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // reset settings: ties, extreme distances, inverted ranges, ignored fields
    queue_item(OP_WRITE_ENTRY, 0, 0, 0, 0, 0, 0);
    queue_item(OP_WRITE_ENTRY, 1, 255, 255, 255, 255, 255);
    queue_item(OP_WRITE_ENTRY, 2, 0, 0, 0, 0, 0);
    queue_item(OP_WRITE_ENTRY, 3, 128, 64, 200, 255, 0);
    queue_item(OP_WRITE_ENTRY, 255, 255, 0, 255, 0, 255);
    queue_item(OP_QUERY, 0, 255, 255, 255, 0, 0);
    queue_item(OP_QUERY, 0, 0, 0, 0, 0, 2);
    queue_item(OP_QUERY, 0, 0, 0, 0, 1, 2);
    queue_item(OP_QUERY, 0, 255, 255, 255, 0, 3);
    queue_item(OP_QUERY, 0, 130, 60, 199, 3, 3);
    queue_item(OP_QUERY, 0, 255, 0, 255, 255, 255);
    queue_item(OP_QUERY, 0, 0, 0, 0, 3, 2);
    queue_item(OP_QUERY, 0, 0, 0, 0, 255, 0);
    queue_item(OP_QUERY, 255, 127, 127, 127, 0, 3);
    drain_block();

    // not indexed: takes precedence over the range check; writes still land
    program_register(pncs_pkg::CFG_INDEXED_MODE, $urandom_range(0, 255) << 1);
    queue_item(OP_QUERY, 0, 0, 0, 0, 0, 255);
    queue_item(OP_QUERY, 0, 0, 0, 0, 200, 10);
    queue_item(OP_WRITE_ENTRY, 4, 10, 20, 30, 0, 0);
    drain_block();

    // smallest palette in use
    program_register(pncs_pkg::CFG_INDEXED_MODE, 1);
    program_register(pncs_pkg::CFG_PALETTE_SIZE, 1);
    queue_item(OP_QUERY, 0, 10, 20, 30, 0, 0);
    queue_item(OP_QUERY, 0, 10, 20, 30, 0, 1);
    queue_item(OP_QUERY, 0, 10, 20, 30, 4, 4);
    drain_block();

    program_register(pncs_pkg::CFG_PALETTE_SIZE, PALETTE_DEPTH);
    queue_item(OP_QUERY, 0, 10, 20, 30, 4, 4);
    for (int i = 0; i < PALETTE_DEPTH; i++)
      queue_item(OP_WRITE_ENTRY, i, pick_channel(), pick_channel(), pick_channel(),
                 $urandom, $urandom);
    long_hold_req = 1'b1;
    queue_random_mix(200);
    drain_block();

    program_register(pncs_pkg::CFG_PALETTE_SIZE, $urandom_range(2, 255));
    queue_random_mix(200);
    drain_block();

    program_register(pncs_pkg::CFG_INDEXED_MODE, 0);
    queue_random_mix(60);
    drain_block();

    program_register(pncs_pkg::CFG_INDEXED_MODE, 1);
    program_register(pncs_pkg::CFG_PALETTE_SIZE, 1);
    queue_random_mix(60);
    drain_block();

    program_register(pncs_pkg::CFG_PALETTE_SIZE, PALETTE_DEPTH);
    queue_random_mix(100);
    drain_block();

    while (expected_matches.size() != 0) begin
      left_over = expected_matches.pop_front();
      flag_error("missing result, status", 0, left_over.status);
    end
    if (err_count == 0) begin
      $display("palette_nearest_color_search: match");
    end else begin
      $display("palette_nearest_color_search: mismatch");
    end
    $finish;
  end

endmodule
